/* hw/rtl/kft_pkg.sv */
// Shared types, constants and helper functions of the two-state Kalman filter core.
`default_nettype none

package kft_pkg;

  localparam int FRAC_BITS = 16;
  localparam logic signed [31:0] ONE_FX = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] HALF_FX = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] MAX32 = 64'sd2147483647;
  localparam logic signed [63:0] MIN32 = -64'sd2147483648;

  // Divider widths: magnitude of num * 2^FRAC_BITS plus half the divisor.
  localparam int QW = 32 + FRAC_BITS;
  localparam int DW = QW + 1;
  localparam int DCW = $clog2(DW + 1);

  localparam int PCW = 5;
  localparam logic [PCW-1:0] OP_S        = PCW'(4);
  localparam logic [PCW-1:0] OP_X0       = PCW'(5);
  localparam logic [PCW-1:0] OP_UPD_LAST = PCW'(14);
  localparam logic [PCW-1:0] OP_PRED     = PCW'(15);
  localparam logic [PCW-1:0] OP_LAST     = PCW'(24);

  typedef struct packed {
    logic              action;
    logic signed [31:0] measurement;
    logic signed [31:0] motion_pos;
    logic signed [31:0] motion_vel;
  } kft_in_t;

  typedef struct packed {
    logic signed [31:0] est_pos;
    logic signed [31:0] est_vel;
    logic signed [31:0] cov_00;
    logic signed [31:0] cov_01;
    logic signed [31:0] cov_10;
    logic signed [31:0] cov_11;
    logic              update_skipped;
    logic              saturated;
  } kft_out_t;

  typedef enum logic [2:0] {
    REG_TRANS_00      = 3'd0,
    REG_TRANS_01      = 3'd1,
    REG_TRANS_10      = 3'd2,
    REG_TRANS_11      = 3'd3,
    REG_MEAS_GAIN_POS = 3'd4,
    REG_MEAS_GAIN_VEL = 3'd5,
    REG_MEAS_NOISE    = 3'd6,
    REG_P_INIT        = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] f00;
    logic signed [31:0] f01;
    logic signed [31:0] f10;
    logic signed [31:0] f11;
    logic signed [31:0] h0;
    logic signed [31:0] h1;
    logic [30:0]        r;
    logic [30:0]        p_init;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] x0, x1;
    logic signed [31:0] p0, p1, p2, p3;
    logic signed [31:0] z, u0, u1;
    logic signed [31:0] hx, y, a0, a1, s, k0, k1;
    logic signed [31:0] m0, m1, m2, m3;
    logic signed [31:0] t0, t1, t2, t3;
    logic signed [31:0] e0, e1;
  } work_t;

  // State after reset: zero estimate, default p_init on the covariance diagonal.
  localparam logic signed [31:0] P_INIT_RST = 32'sd6553600;
  localparam work_t WORK_RST = '{p0: P_INIT_RST, p3: P_INIT_RST, default: 32'sd0};

  typedef enum logic [5:0] {
    SEL_ZERO, SEL_ONE,
    SEL_X0, SEL_X1, SEL_P0, SEL_P1, SEL_P2, SEL_P3,
    SEL_Z, SEL_U0, SEL_U1, SEL_R,
    SEL_F00, SEL_F01, SEL_F10, SEL_F11, SEL_H0, SEL_H1,
    SEL_HX, SEL_Y, SEL_A0, SEL_A1, SEL_S, SEL_K0, SEL_K1,
    SEL_M0, SEL_M1, SEL_M2, SEL_M3,
    SEL_T0, SEL_T1, SEL_T2, SEL_T3, SEL_E0, SEL_E1
  } sel_t;

  // One dot product: dst = sat(add +/- rnd(a0*b0) +/- rnd(a1*b1)).
  typedef struct packed {
    sel_t a0, b0, a1, b1, add, dst;
    logic neg0, neg1;
  } op_t;

  function automatic op_t mk(sel_t a0, sel_t b0, sel_t a1, sel_t b1, sel_t add,
                             sel_t dst, logic neg0, logic neg1);
    op_t o;
    o.a0 = a0; o.b0 = b0; o.a1 = a1; o.b1 = b1;
    o.add = add; o.dst = dst; o.neg0 = neg0; o.neg1 = neg1;
    return o;
  endfunction

  function automatic op_t op_rom(logic [PCW-1:0] pc);
    op_t o;
    case (pc)
      5'd0:  o = mk(SEL_H0, SEL_X0, SEL_H1, SEL_X1, SEL_ZERO, SEL_HX, 1'b0, 1'b0);
      5'd1:  o = mk(SEL_Z, SEL_ONE, SEL_HX, SEL_ONE, SEL_ZERO, SEL_Y, 1'b0, 1'b1);
      5'd2:  o = mk(SEL_P0, SEL_H0, SEL_P1, SEL_H1, SEL_ZERO, SEL_A0, 1'b0, 1'b0);
      5'd3:  o = mk(SEL_P2, SEL_H0, SEL_P3, SEL_H1, SEL_ZERO, SEL_A1, 1'b0, 1'b0);
      5'd4:  o = mk(SEL_H0, SEL_A0, SEL_H1, SEL_A1, SEL_R, SEL_S, 1'b0, 1'b0);
      5'd5:  o = mk(SEL_K0, SEL_Y, SEL_X0, SEL_ONE, SEL_ZERO, SEL_X0, 1'b0, 1'b0);
      5'd6:  o = mk(SEL_K1, SEL_Y, SEL_X1, SEL_ONE, SEL_ZERO, SEL_X1, 1'b0, 1'b0);
      5'd7:  o = mk(SEL_K0, SEL_H0, SEL_ZERO, SEL_ZERO, SEL_ONE, SEL_M0, 1'b1, 1'b0);
      5'd8:  o = mk(SEL_K0, SEL_H1, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_M1, 1'b1, 1'b0);
      5'd9:  o = mk(SEL_K1, SEL_H0, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_M2, 1'b1, 1'b0);
      5'd10: o = mk(SEL_K1, SEL_H1, SEL_ZERO, SEL_ZERO, SEL_ONE, SEL_M3, 1'b1, 1'b0);
      5'd11: o = mk(SEL_M0, SEL_P0, SEL_M1, SEL_P2, SEL_ZERO, SEL_T0, 1'b0, 1'b0);
      5'd12: o = mk(SEL_M0, SEL_P1, SEL_M1, SEL_P3, SEL_ZERO, SEL_T1, 1'b0, 1'b0);
      5'd13: o = mk(SEL_M2, SEL_P0, SEL_M3, SEL_P2, SEL_ZERO, SEL_T2, 1'b0, 1'b0);
      5'd14: o = mk(SEL_M2, SEL_P1, SEL_M3, SEL_P3, SEL_ZERO, SEL_T3, 1'b0, 1'b0);
      5'd15: o = mk(SEL_F00, SEL_X0, SEL_F01, SEL_X1, SEL_U0, SEL_E0, 1'b0, 1'b0);
      5'd16: o = mk(SEL_F10, SEL_X0, SEL_F11, SEL_X1, SEL_U1, SEL_E1, 1'b0, 1'b0);
      5'd17: o = mk(SEL_F00, SEL_P0, SEL_F01, SEL_P2, SEL_ZERO, SEL_T0, 1'b0, 1'b0);
      5'd18: o = mk(SEL_F00, SEL_P1, SEL_F01, SEL_P3, SEL_ZERO, SEL_T1, 1'b0, 1'b0);
      5'd19: o = mk(SEL_F10, SEL_P0, SEL_F11, SEL_P2, SEL_ZERO, SEL_T2, 1'b0, 1'b0);
      5'd20: o = mk(SEL_F10, SEL_P1, SEL_F11, SEL_P3, SEL_ZERO, SEL_T3, 1'b0, 1'b0);
      5'd21: o = mk(SEL_T0, SEL_F00, SEL_T1, SEL_F01, SEL_ZERO, SEL_P0, 1'b0, 1'b0);
      5'd22: o = mk(SEL_T0, SEL_F10, SEL_T1, SEL_F11, SEL_ZERO, SEL_P1, 1'b0, 1'b0);
      5'd23: o = mk(SEL_T2, SEL_F00, SEL_T3, SEL_F01, SEL_ZERO, SEL_P2, 1'b0, 1'b0);
      5'd24: o = mk(SEL_T2, SEL_F10, SEL_T3, SEL_F11, SEL_ZERO, SEL_P3, 1'b0, 1'b0);
      default: o = mk(SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO,
                      1'b0, 1'b0);
    endcase
    return o;
  endfunction

  function automatic logic signed [31:0] sel_value(sel_t s, cfg_t c, work_t w);
    logic signed [31:0] v;
    case (s)
      SEL_ONE: v = ONE_FX;
      SEL_X0:  v = w.x0;
      SEL_X1:  v = w.x1;
      SEL_P0:  v = w.p0;
      SEL_P1:  v = w.p1;
      SEL_P2:  v = w.p2;
      SEL_P3:  v = w.p3;
      SEL_Z:   v = w.z;
      SEL_U0:  v = w.u0;
      SEL_U1:  v = w.u1;
      SEL_R:   v = {1'b0, c.r};
      SEL_F00: v = c.f00;
      SEL_F01: v = c.f01;
      SEL_F10: v = c.f10;
      SEL_F11: v = c.f11;
      SEL_H0:  v = c.h0;
      SEL_H1:  v = c.h1;
      SEL_HX:  v = w.hx;
      SEL_Y:   v = w.y;
      SEL_A0:  v = w.a0;
      SEL_A1:  v = w.a1;
      SEL_S:   v = w.s;
      SEL_K0:  v = w.k0;
      SEL_K1:  v = w.k1;
      SEL_M0:  v = w.m0;
      SEL_M1:  v = w.m1;
      SEL_M2:  v = w.m2;
      SEL_M3:  v = w.m3;
      SEL_T0:  v = w.t0;
      SEL_T1:  v = w.t1;
      SEL_T2:  v = w.t2;
      SEL_T3:  v = w.t3;
      SEL_E0:  v = w.e0;
      SEL_E1:  v = w.e1;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic work_t work_write(work_t w, sel_t d, logic signed [31:0] v);
    work_t o;
    o = w;
    case (d)
      SEL_X0: o.x0 = v;
      SEL_X1: o.x1 = v;
      SEL_P0: o.p0 = v;
      SEL_P1: o.p1 = v;
      SEL_P2: o.p2 = v;
      SEL_P3: o.p3 = v;
      SEL_HX: o.hx = v;
      SEL_Y:  o.y = v;
      SEL_A0: o.a0 = v;
      SEL_A1: o.a1 = v;
      SEL_S:  o.s = v;
      SEL_K0: o.k0 = v;
      SEL_K1: o.k1 = v;
      SEL_M0: o.m0 = v;
      SEL_M1: o.m1 = v;
      SEL_M2: o.m2 = v;
      SEL_M3: o.m3 = v;
      SEL_T0: o.t0 = v;
      SEL_T1: o.t1 = v;
      SEL_T2: o.t2 = v;
      SEL_T3: o.t3 = v;
      SEL_E0: o.e0 = v;
      SEL_E1: o.e1 = v;
      default: o = w;
    endcase
    return o;
  endfunction

  // Round a full product to FRAC_BITS fraction bits: add half an LSB, then floor.
  function automatic logic signed [63:0] rnd(logic signed [63:0] p);
    return (p + HALF_FX) >>> FRAC_BITS;
  endfunction

  // Saturate to 32 bits; the top bit of the result is the clip flag.
  function automatic logic [32:0] sat32(logic signed [63:0] v);
    logic [32:0] o;
    if (v > MAX32) begin
      o = {1'b1, 32'h7fff_ffff};
    end else if (v < MIN32) begin
      o = {1'b1, 32'h8000_0000};
    end else begin
      o = {1'b0, v[31:0]};
    end
    return o;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/kft_if.sv */
// Channel interfaces of the Kalman filter core: input, result and configuration.
`default_nettype none

interface kft_in_if;
  import kft_pkg::*;
  logic    valid;
  logic    ready;
  kft_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kft_out_if;
  import kft_pkg::*;
  logic     valid;
  logic     ready;
  kft_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kft_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/kalman_filter_two_state_core.sv */
// Top level of the two-state Kalman filter core: sequencer, shared multiplier and state.
//
// Usage: in_ch carries one transaction per filter step (action, measurement, motion
// terms); out_ch returns exactly one transaction per accepted input with the
// predicted estimate, the covariance and the skip and saturation flags. cfg_ch
// writes the F, H, R and p_init registers; it is always ready and must only be
// used while the core is idle.
// A step runs as a list of 25 two-term dot products on one 32x32 multiplier,
// each one multiplied in ST_MUL0 and ST_MUL1 and written in ST_ACC, plus two serial
// divisions for the gain. A step whose innovation covariance is not positive
// skips the correction; a restart goes straight to ST_DONE. in_ch.ready is high only
// while no step is in progress. The result sits in an output register, so the
// next input is taken while it waits; a step that finishes while the previous
// result is still stalled holds until out_ch.ready frees the register.
// Reset restores the register defaults, zeroes the estimate and loads the
// default p_init on the covariance diagonal.
`default_nettype none

module kalman_filter_two_state_core (
  input  wire logic clk,
  input  wire logic rst_n,
  kft_in_if.sink    in_ch,
  kft_out_if.source out_ch,
  kft_cfg_if.sink   cfg_ch
);
  import kft_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL0 = 7'b0000010,
    ST_MUL1 = 7'b0000100,
    ST_ACC  = 7'b0001000,
    ST_DIV  = 7'b0010000,
    ST_COPY = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [PCW-1:0]     pc_r, pc_nxt;
  cfg_t               cfg_r;
  work_t              work_r, work_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic signed [63:0] acc_r, acc_nxt;
  logic               skip_r, skip_nxt;
  logic               sat_r, sat_nxt;
  logic               div_idx_r, div_idx_nxt;
  logic               div_run_r, div_run_nxt;
  logic               out_valid_r, out_valid_nxt;
  kft_out_t           out_data_r, out_data_nxt;

  op_t                op;
  sel_t               a_sel, b_sel;
  logic signed [31:0] opa, opb, addv;
  logic signed [63:0] r_prod, sum;
  logic [32:0]        res_sat;
  logic signed [31:0] res;
  logic               div_start, div_done;
  logic signed [DW:0] div_quot;
  logic [32:0]        k_sat;
  logic               in_acc;

  assign op     = op_rom(pc_r);
  assign a_sel  = (state_r == ST_MUL0) ? op.a0 : op.a1;
  assign b_sel  = (state_r == ST_MUL0) ? op.b0 : op.b1;
  assign opa    = sel_value(a_sel, cfg_r, work_r);
  assign opb    = sel_value(b_sel, cfg_r, work_r);
  assign addv   = sel_value(op.add, cfg_r, work_r);
  assign r_prod = rnd(prod_r);
  assign sum    = acc_r + (op.neg1 ? -r_prod : r_prod);
  assign res_sat = sat32(sum);
  assign res     = res_sat[31:0];

  assign div_start = (state_r == ST_DIV) && !div_run_r;
  assign k_sat     = sat32(64'(div_quot));
  assign in_acc    = in_ch.valid && in_ch.ready;

  kft_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_idx_r ? work_r.a1 : work_r.a0),
    .den   (work_r.s[30:0]),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    work_nxt      = work_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    skip_nxt      = skip_r;
    sat_nxt       = sat_r;
    div_idx_nxt   = div_idx_r;
    div_run_nxt   = div_run_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_ch.valid && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          skip_nxt = 1'b0;
          sat_nxt  = 1'b0;
          if (in_ch.data.action) begin
            work_nxt.x0 = '0;
            work_nxt.x1 = '0;
            work_nxt.p0 = {1'b0, cfg_r.p_init};
            work_nxt.p1 = '0;
            work_nxt.p2 = '0;
            work_nxt.p3 = {1'b0, cfg_r.p_init};
            state_nxt   = ST_DONE;
          end else begin
            work_nxt.z  = in_ch.data.measurement;
            work_nxt.u0 = in_ch.data.motion_pos;
            work_nxt.u1 = in_ch.data.motion_vel;
            pc_nxt      = '0;
            state_nxt   = ST_MUL0;
          end
        end
      end
      ST_MUL0: begin
        prod_nxt  = opa * opb;
        state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        acc_nxt   = 64'(addv) + (op.neg0 ? -r_prod : r_prod);
        prod_nxt  = opa * opb;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        work_nxt = work_write(work_r, op.dst, res);
        sat_nxt  = sat_r | res_sat[32];
        if (pc_r == OP_S) begin
          if (res[31] || (res == '0)) begin
            skip_nxt  = 1'b1;
            pc_nxt    = OP_PRED;
            state_nxt = ST_MUL0;
          end else begin
            div_idx_nxt = 1'b0;
            state_nxt   = ST_DIV;
          end
        end else if (pc_r == OP_UPD_LAST) begin
          state_nxt = ST_COPY;
        end else if (pc_r == OP_LAST) begin
          // The predicted estimate replaces the state together with the last entry.
          work_nxt.x0 = work_r.e0;
          work_nxt.x1 = work_r.e1;
          state_nxt   = ST_DONE;
        end else begin
          pc_nxt    = pc_r + 1'b1;
          state_nxt = ST_MUL0;
        end
      end
      ST_DIV: begin
        if (div_start) begin
          div_run_nxt = 1'b1;
        end else if (div_done) begin
          div_run_nxt = 1'b0;
          sat_nxt     = sat_r | k_sat[32];
          if (div_idx_r) begin
            work_nxt.k1 = k_sat[31:0];
            pc_nxt      = OP_X0;
            state_nxt   = ST_MUL0;
          end else begin
            work_nxt.k0 = k_sat[31:0];
            div_idx_nxt = 1'b1;
          end
        end
      end
      ST_COPY: begin
        work_nxt.p0 = work_r.t0;
        work_nxt.p1 = work_r.t1;
        work_nxt.p2 = work_r.t2;
        work_nxt.p3 = work_r.t3;
        pc_nxt      = OP_PRED;
        state_nxt   = ST_MUL0;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.est_pos        = work_r.x0;
          out_data_nxt.est_vel        = work_r.x1;
          out_data_nxt.cov_00         = work_r.p0;
          out_data_nxt.cov_01         = work_r.p1;
          out_data_nxt.cov_10         = work_r.p2;
          out_data_nxt.cov_11         = work_r.p3;
          out_data_nxt.update_skipped = skip_r;
          out_data_nxt.saturated      = sat_r;
          state_nxt                   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= '0;
      div_idx_r   <= 1'b0;
      div_run_r   <= 1'b0;
      out_valid_r <= 1'b0;
      skip_r      <= 1'b0;
      sat_r       <= 1'b0;
      work_r      <= WORK_RST;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      div_idx_r   <= div_idx_nxt;
      div_run_r   <= div_run_nxt;
      out_valid_r <= out_valid_nxt;
      skip_r      <= skip_nxt;
      sat_r       <= sat_nxt;
      work_r      <= work_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.f00    <= 32'sd65536;
      cfg_r.f01    <= 32'sd65536;
      cfg_r.f10    <= '0;
      cfg_r.f11    <= 32'sd65536;
      cfg_r.h0     <= 32'sd65536;
      cfg_r.h1     <= '0;
      cfg_r.r      <= 31'd65536;
      cfg_r.p_init <= 31'd6553600;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (reg_idx_t'(cfg_ch.index))
        REG_TRANS_00:      cfg_r.f00    <= cfg_ch.data;
        REG_TRANS_01:      cfg_r.f01    <= cfg_ch.data;
        REG_TRANS_10:      cfg_r.f10    <= cfg_ch.data;
        REG_TRANS_11:      cfg_r.f11    <= cfg_ch.data;
        REG_MEAS_GAIN_POS: cfg_r.h0     <= cfg_ch.data;
        REG_MEAS_GAIN_VEL: cfg_r.h1     <= cfg_ch.data;
        REG_MEAS_NOISE:    cfg_r.r      <= cfg_ch.data[30:0];
        REG_P_INIT:        cfg_r.p_init <= cfg_ch.data[30:0];
        default:           cfg_r        <= cfg_r;
      endcase
    end
  end

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule

`default_nettype wire

/* hw/rtl/kft_div.sv */
// Restoring serial divider for the gain: round(num * 2^FRAC_BITS / den), one bit per cycle.
`default_nettype none

module kft_div (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [31:0]      num,
  input  wire logic [30:0]             den,
  output logic                         done,
  output logic signed [kft_pkg::DW:0]  quot
);
  import kft_pkg::*;

  logic [DW-1:0]  dvd_r, dvd_nxt;
  logic [30:0]    rem_r, rem_nxt;
  logic [30:0]    den_r;
  logic [DCW-1:0] cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic           neg_r;
  logic [31:0]    mag;
  logic [31:0]    trial;
  logic           ge;

  assign mag   = num[31] ? 32'(-num) : 32'(num);
  assign trial = {rem_r, dvd_r[DW-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      // Adding half the divisor up front turns the floor into round-half-away.
      dvd_nxt  = DW'({mag, {FRAC_BITS{1'b0}}}) + DW'(den >> 1);
      rem_nxt  = '0;
      cnt_nxt  = DCW'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? 31'(trial - {1'b0, den_r}) : trial[30:0];
      dvd_nxt = {dvd_r[DW-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DCW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= den;
      neg_r <= num[31];
    end
  end

  assign done = done_r;
  assign quot = neg_r ? -$signed({1'b0, dvd_r}) : $signed({1'b0, dvd_r});

endmodule

`default_nettype wire

/* hw/rtl/kft_checker.sv */
// Port-level checker of the Kalman filter core and its bind to the top level.
`default_nettype none

module kft_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_valid,
  input wire logic           in_ready,
  input wire logic           in_action,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire kft_pkg::kft_out_t out_data
);
  import kft_pkg::*;

  // The core works on one step at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a step was starting");

  // A restart produces its result without going through the arithmetic.
  a_restart_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_action && !out_valid |-> ##2 out_valid)
    else $error("restart result did not appear");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A restart result never reports a skipped update or saturation.
  a_restart_flags: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_action && !out_valid |-> ##2
      (!out_data.update_skipped && !out_data.saturated))
    else $error("restart result carries flags");

endmodule

bind kalman_filter_two_state_core kft_checker u_kft_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_action (in_ch.data.action),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

`default_nettype wire
